// ===== design/aabb_triangle_overlap_macros.svh =====
// assertion macros for the triangle versus box overlap block
// no dependencies
`ifndef AABB_TRIANGLE_OVERLAP_MACROS_SVH
`define AABB_TRIANGLE_OVERLAP_MACROS_SVH
// implication checked every clock outside reset
`define ATO_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ATO_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/ato_pkg.sv =====
// package for the triangle versus box overlap block
// holds coordinate width, pipeline depth and configuration register indexes
package ato_pkg;
  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0, REG_MIN_Y = 3'd1, REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3, REG_MAX_Y = 3'd4, REG_MAX_Z = 3'd5
  } cfg_reg_t;
  localparam int unsigned PIPE_DEPTH = 6;
endpackage

// ===== design/aabb_triangle_overlap.sv =====
// triangle versus axis-aligned box overlap by the separating-axis test
// out_valid is the last bit of the valid shift register that runs beside the data (6 stages)
// throughput one item per cycle; busy is held low since results cannot be held off
// stages: differences, normal, edge products, normal limb products, sums, compare
// reset (synchronous, rst_n low) clears the box registers to 0 and all valid bits
// depends on ato_pkg
module aabb_triangle_overlap import ato_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [31:0]          in_v0_x, input logic [31:0] in_v0_y,
  input  logic [31:0]          in_v0_z,
  input  logic [31:0]          in_v1_x, input logic [31:0] in_v1_y,
  input  logic [31:0]          in_v1_z,
  input  logic [31:0]          in_v2_x, input logic [31:0] in_v2_y,
  input  logic [31:0]          in_v2_z,
  output logic                 out_valid,
  output logic                 out_overlap,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);
  // widths: coordinate C, doubled/differences D=C+2, normal components N=2D+1,
  // normal split into an unsigned low limb of H bits and a signed high limb,
  // limb products PP, projections P = D+N+3 (three terms), edge projections PE
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned D  = C + 2;
  localparam int unsigned N  = 2*D + 1;
  localparam int unsigned H  = D;
  localparam int unsigned PP = D + H + 1;
  localparam int unsigned P  = D + N + 3;
  localparam int unsigned PE = D + D + 3;

  assign busy = 1'b0;

  logic signed [C-1:0] bmin_r [3];
  logic signed [C-1:0] bmax_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        bmin_r[k] <= '0;
        bmax_r[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_X: bmin_r[0] <= cfg_data[C-1:0];
        REG_MIN_Y: bmin_r[1] <= cfg_data[C-1:0];
        REG_MIN_Z: bmin_r[2] <= cfg_data[C-1:0];
        REG_MAX_X: bmax_r[0] <= cfg_data[C-1:0];
        REG_MAX_Y: bmax_r[1] <= cfg_data[C-1:0];
        REG_MAX_Z: bmax_r[2] <= cfg_data[C-1:0];
        default: ;
      endcase
    end
  end

  // coordinates taken from the low COORD_BITS bits of each field
  logic signed [C-1:0] vin [3][3];
  always_comb begin
    vin[0][0] = in_v0_x[C-1:0]; vin[0][1] = in_v0_y[C-1:0]; vin[0][2] = in_v0_z[C-1:0];
    vin[1][0] = in_v1_x[C-1:0]; vin[1][1] = in_v1_y[C-1:0]; vin[1][2] = in_v1_z[C-1:0];
    vin[2][0] = in_v2_x[C-1:0]; vin[2][1] = in_v2_y[C-1:0]; vin[2][2] = in_v2_z[C-1:0];
  end

  logic [PIPE_DEPTH-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[PIPE_DEPTH-2:0], start};
  end
  assign out_valid = vld_r[PIPE_DEPTH-1];

  // stage 1: doubled centered vertices, edges, extents
  logic signed [D-1:0] w1_r [3][3];
  logic signed [D-1:0] f1_r [3][3];
  logic signed [D-1:0] e1_r [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e1_r[k] <= D'(bmax_r[k]) - D'(bmin_r[k]);
      for (int i = 0; i < 3; i++) begin
        w1_r[i][k] <= (D'(vin[i][k]) <<< 1) - D'(bmin_r[k]) - D'(bmax_r[k]);
        f1_r[i][k] <= D'(vin[(i+1)%3][k]) - D'(vin[i][k]);
      end
    end
  end

  // stage 2: normal components (two products each)
  logic signed [N-1:0] n2_r [3];
  logic signed [D-1:0] w2_r [3][3];
  logic signed [D-1:0] f2_r [3][3];
  logic signed [D-1:0] e2_r [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      n2_r[k] <= N'(f1_r[0][(k+1)%3]) * N'(f1_r[1][(k+2)%3])
               - N'(f1_r[0][(k+2)%3]) * N'(f1_r[1][(k+1)%3]);
    end
    w2_r <= w1_r; f2_r <= f1_r; e2_r <= e1_r;
  end

  // stage 3: normal magnitude, edge-axis products, face-axis test
  logic signed [N-1:0]  n3_r  [3];
  logic signed [N-1:0]  na3_r [3];
  logic                 nz3_r;
  logic signed [PE-1:0] pe3_r [3][3][3][2];
  logic signed [PE-1:0] re3_r [3][3][2];
  logic                 fz3_r [3][3];
  logic                 sepf3_r;
  logic signed [D-1:0]  w3_r [3][3];
  logic signed [D-1:0]  e3_r [3];
  logic                 sep_f;
  // face axes: projection is w itself, radius e
  always_comb begin
    sep_f = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if ((w2_r[0][k] > e2_r[k] && w2_r[1][k] > e2_r[k] && w2_r[2][k] > e2_r[k])
          || (w2_r[0][k] < -e2_r[k] && w2_r[1][k] < -e2_r[k]
              && w2_r[2][k] < -e2_r[k]))
        sep_f = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    nz3_r <= (n2_r[0] == '0) && (n2_r[1] == '0) && (n2_r[2] == '0);
    for (int k = 0; k < 3; k++) begin
      n3_r[k]  <= n2_r[k];
      na3_r[k] <= n2_r[k][N-1] ? -n2_r[k] : n2_r[k];
    end
    // axis k x f_i = (0, -f[k2], f[k1]) in rotated form
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        // edge parallel to box axis k gives a zero axis, skipped
        fz3_r[k][i] <= (f2_r[i][(k+1)%3] == '0) && (f2_r[i][(k+2)%3] == '0);
        re3_r[k][i][0] <= PE'(e2_r[(k+1)%3])
          * PE'(f2_r[i][(k+2)%3][D-1] ? -f2_r[i][(k+2)%3] : f2_r[i][(k+2)%3]);
        re3_r[k][i][1] <= PE'(e2_r[(k+2)%3])
          * PE'(f2_r[i][(k+1)%3][D-1] ? -f2_r[i][(k+1)%3] : f2_r[i][(k+1)%3]);
        for (int j = 0; j < 3; j++) begin
          pe3_r[k][i][j][0] <= -(PE'(w2_r[j][(k+1)%3]) * PE'(f2_r[i][(k+2)%3]));
          pe3_r[k][i][j][1] <= PE'(w2_r[j][(k+2)%3]) * PE'(f2_r[i][(k+1)%3]);
        end
      end
    end
    sepf3_r <= sep_f;
    w3_r <= w2_r; e3_r <= e2_r;
  end

  // stage 4: normal products by limb, edge-axis sums
  logic signed [PP-1:0] pnl4_r [3][3];
  logic signed [PP-1:0] pnh4_r [3][3];
  logic signed [PP-1:0] rnl4_r [3];
  logic signed [PP-1:0] rnh4_r [3];
  logic signed [PE-1:0] pe4_r [3][3][3];
  logic signed [PE-1:0] re4_r [3][3];
  logic                 fz4_r [3][3];
  logic                 nz4_r, sepf4_r;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      rnl4_r[k] <= PP'(e3_r[k]) * PP'($signed({1'b0, na3_r[k][H-1:0]}));
      rnh4_r[k] <= PP'(e3_r[k]) * PP'($signed(na3_r[k][N-1:H]));
      for (int i = 0; i < 3; i++) begin
        pnl4_r[i][k] <= PP'(w3_r[i][k]) * PP'($signed({1'b0, n3_r[k][H-1:0]}));
        pnh4_r[i][k] <= PP'(w3_r[i][k]) * PP'($signed(n3_r[k][N-1:H]));
        re4_r[k][i] <= re3_r[k][i][0] + re3_r[k][i][1];
        for (int j = 0; j < 3; j++)
          pe4_r[k][i][j] <= pe3_r[k][i][j][0] + pe3_r[k][i][j][1];
      end
    end
    fz4_r <= fz3_r; nz4_r <= nz3_r; sepf4_r <= sepf3_r;
  end

  // stage 5: normal projections and radius from limbs, edge-axis flags
  logic signed [P-1:0]  pn5_r [3];
  logic signed [P-1:0]  rn5_r;
  logic                 nz5_r, sepf5_r, sepe5_r;
  logic signed [PE-1:0] pe  [3];
  logic signed [PE-1:0] re;
  logic signed [PE-1:0] emin, emax;
  logic                 sep_e;
  always_comb begin
    sep_e = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        re = re4_r[k][i];
        for (int j = 0; j < 3; j++) pe[j] = pe4_r[k][i][j];
        emin = pe[0]; emax = pe[0];
        for (int j = 1; j < 3; j++) begin
          if (pe[j] < emin) emin = pe[j];
          if (pe[j] > emax) emax = pe[j];
        end
        if (!fz4_r[k][i] && ((emax < -re) || (emin > re)))
          sep_e = 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      pn5_r[i] <= ((P'(pnh4_r[i][0]) + P'(pnh4_r[i][1]) + P'(pnh4_r[i][2])) <<< H)
                + P'(pnl4_r[i][0]) + P'(pnl4_r[i][1]) + P'(pnl4_r[i][2]);
    rn5_r <= ((P'(rnh4_r[0]) + P'(rnh4_r[1]) + P'(rnh4_r[2])) <<< H)
           + P'(rnl4_r[0]) + P'(rnl4_r[1]) + P'(rnl4_r[2]);
    sepe5_r <= sep_e;
    nz5_r   <= nz4_r;
    sepf5_r <= sepf4_r;
  end

  // stage 6: normal-axis compare and result register
  logic signed [P-1:0] nmin, nmax;
  logic                sep_n;
  always_comb begin
    nmin = pn5_r[0]; nmax = pn5_r[0];
    for (int i = 1; i < 3; i++) begin
      if (pn5_r[i] < nmin) nmin = pn5_r[i];
      if (pn5_r[i] > nmax) nmax = pn5_r[i];
    end
    sep_n = !nz5_r && ((nmax < -rn5_r) || (nmin > rn5_r));
  end
  logic ovl6_r;
  always_ff @(posedge clk) ovl6_r <= !(sep_n || sepe5_r || sepf5_r);
  assign out_overlap = ovl6_r;
endmodule

// ===== design/ato_checker.sv =====
// port-level checker for the overlap block, bound to the top level
// depends on ato_pkg and aabb_triangle_overlap_macros.svh
`include "aabb_triangle_overlap_macros.svh"
module ato_checker import ato_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  `ATO_ASSERT_IMP(a_never_busy, 1'b1, !busy)
  `ATO_ASSERT_NXT(a_start_gives_result, start, ##(PIPE_DEPTH-1) out_valid)
  `ATO_ASSERT_IMP(a_result_from_item, out_valid, $past(start, PIPE_DEPTH))
endmodule

bind aabb_triangle_overlap ato_checker u_ato_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);
